@@ hdl/pfla_pkg.sv @@
// Package for the page free-list allocator: sizes, command and status codes, memory word.
package pfla_pkg;

  localparam int PAGES   = 1024;
  localparam int ADDR_W  = $clog2(PAGES);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 12;
  localparam int STAT_W  = 3;
  localparam int PNUM_W  = 10;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DISPOSE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PREV    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_CLOSED  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_INVALID = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FREE    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EOF     = 3'd4;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd5;

  // one page entry: used mark and free-list link
  typedef struct packed {
    logic             used;
    logic [CNT_W-1:0] next_free;
  } page_word_t;

endpackage

@@ hdl/page_free_list_allocator_core.sv @@
// Page free-list allocator: one command word in, one status word out. Per-page used marks
// and free-list links share one RAM (one write, one registered read per cycle); the contents
// of entries at or above the page count are never used, so no clearing pass follows reset.
// Alloc, dispose and get pass from accept through decode, at most one RAM read and the
// result register; next and prev scans read one used mark per cycle up to the hit or to the
// end of the file. One command is in flight at a time; the next one is taken while the
// previous result waits on out_stall.
module page_free_list_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfla_pkg::CMD_W-1:0]    in_cmd,
  input  logic signed [pfla_pkg::IDX_W-1:0] in_page_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfla_pkg::STAT_W-1:0]   out_status,
  output logic [pfla_pkg::PNUM_W-1:0]   out_page_number
);

  localparam int AW = pfla_pkg::ADDR_W;
  localparam int CW = pfla_pkg::CNT_W;
  localparam int EW = pfla_pkg::IDX_W + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_MEM  = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [pfla_pkg::CMD_W-1:0]     cmd_r;
  logic [pfla_pkg::IDX_W-1:0]     idx_r;
  logic                           file_open_r;
  logic [CW-1:0]                  head_r, head_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [AW-1:0]                  ptr_r, ptr_nxt;
  logic [AW-1:0]                  chk_addr_r, chk_addr_nxt;
  logic                           chk_r, chk_nxt;
  logic [pfla_pkg::STAT_W-1:0]    res_status_r, res_status_nxt;
  logic [pfla_pkg::PNUM_W-1:0]    res_page_r, res_page_nxt;
  logic                           out_valid_r;
  logic [pfla_pkg::STAT_W-1:0]    out_status_r;
  logic [pfla_pkg::PNUM_W-1:0]    out_page_r;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  pfla_pkg::page_word_t           ram_wdata, ram_rdata;

  logic                           in_acc, out_load;
  logic signed [EW-1:0]           idx_s, cnt_s;
  logic [AW-1:0]                  idx_addr, last_addr;
  logic [CW-1:0]                  count_m1;
  logic                           fwd, scan_term;

  pfla_ram #(
    .WIDTH ($bits(pfla_pkg::page_word_t)),
    .DEPTH (pfla_pkg::PAGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  assign idx_s     = $signed({idx_r[pfla_pkg::IDX_W-1], idx_r});
  assign cnt_s     = $signed(EW'(count_r));
  assign idx_addr  = idx_r[AW-1:0];
  assign count_m1  = count_r - CW'(1);
  assign last_addr = count_m1[AW-1:0];
  assign fwd       = (cmd_r == pfla_pkg::CMD_NEXT);
  assign scan_term = fwd ? (chk_addr_r == last_addr) : (chk_addr_r == '0);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    chk_addr_nxt   = chk_addr_r;
    chk_nxt        = chk_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_addr;
    ram_wdata      = '{used: 1'b0, next_free: head_r};
    ram_raddr      = idx_addr;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        res_page_nxt = '0;
        state_nxt    = S_OUT;
        if (!file_open_r) begin
          res_status_nxt = pfla_pkg::STAT_CLOSED;
        end else begin
          unique case (cmd_r)
            pfla_pkg::CMD_ALLOC: begin
              if (head_r < CW'(pfla_pkg::PAGES) && head_r < count_r) begin
                ram_raddr = head_r[AW-1:0];
                state_nxt = S_MEM;
              end else if (count_r == CW'(pfla_pkg::PAGES)) begin
                res_status_nxt = pfla_pkg::STAT_FULL;
              end else begin
                // append a fresh page; its link stays unused until disposed
                ram_we         = 1'b1;
                ram_waddr      = count_r[AW-1:0];
                ram_wdata      = '{used: 1'b1, next_free: CW'(pfla_pkg::PAGES)};
                count_nxt      = count_r + CW'(1);
                res_status_nxt = pfla_pkg::STAT_OK;
                res_page_nxt   = pfla_pkg::PNUM_W'(count_r[AW-1:0]);
              end
            end
            pfla_pkg::CMD_DISPOSE, pfla_pkg::CMD_GET: begin
              if (idx_s < 0 || idx_s >= cnt_s) begin
                res_status_nxt = pfla_pkg::STAT_INVALID;
              end else begin
                state_nxt = S_MEM;
              end
            end
            pfla_pkg::CMD_NEXT: begin
              if (idx_s < -1 || idx_s >= cnt_s) begin
                res_status_nxt = pfla_pkg::STAT_INVALID;
              end else if (idx_s + 1 >= cnt_s) begin
                res_status_nxt = pfla_pkg::STAT_EOF;
              end else begin
                ptr_nxt   = idx_addr + AW'(1);
                chk_nxt   = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            pfla_pkg::CMD_PREV: begin
              if (idx_s <= 0 || idx_s > cnt_s) begin
                res_status_nxt = pfla_pkg::STAT_INVALID;
              end else begin
                ptr_nxt   = idx_addr - AW'(1);
                chk_nxt   = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = pfla_pkg::STAT_INVALID;
            end
          endcase
        end
      end

      S_MEM: begin
        state_nxt    = S_OUT;
        res_page_nxt = '0;
        unique case (cmd_r)
          pfla_pkg::CMD_ALLOC: begin
            // pop the list head
            ram_we         = 1'b1;
            ram_waddr      = head_r[AW-1:0];
            ram_wdata      = '{used: 1'b1, next_free: ram_rdata.next_free};
            head_nxt       = ram_rdata.next_free;
            res_status_nxt = pfla_pkg::STAT_OK;
            res_page_nxt   = pfla_pkg::PNUM_W'(head_r[AW-1:0]);
          end
          pfla_pkg::CMD_DISPOSE: begin
            if (!ram_rdata.used) begin
              res_status_nxt = pfla_pkg::STAT_FREE;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = idx_addr;
              ram_wdata      = '{used: 1'b0, next_free: head_r};
              head_nxt       = CW'(idx_addr);
              res_status_nxt = pfla_pkg::STAT_OK;
              res_page_nxt   = pfla_pkg::PNUM_W'(idx_addr);
            end
          end
          default: begin
            if (ram_rdata.used) begin
              res_status_nxt = pfla_pkg::STAT_OK;
              res_page_nxt   = pfla_pkg::PNUM_W'(idx_addr);
            end else begin
              res_status_nxt = pfla_pkg::STAT_INVALID;
            end
          end
        endcase
      end

      S_SCAN: begin
        // read one mark per cycle; rdata belongs to chk_addr_r when chk_r is set
        ram_raddr = ptr_r;
        if (chk_r && ram_rdata.used) begin
          res_status_nxt = pfla_pkg::STAT_OK;
          res_page_nxt   = pfla_pkg::PNUM_W'(chk_addr_r);
          state_nxt      = S_OUT;
        end else if (chk_r && scan_term) begin
          res_status_nxt = pfla_pkg::STAT_EOF;
          res_page_nxt   = '0;
          state_nxt      = S_OUT;
        end else begin
          chk_nxt      = 1'b1;
          chk_addr_nxt = ptr_r;
          ptr_nxt      = fwd ? (ptr_r + AW'(1)) : (ptr_r - AW'(1));
        end
      end

      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      file_open_r <= 1'b0;
      head_r      <= CW'(pfla_pkg::PAGES);
      count_r     <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      chk_r   <= chk_nxt;
      if (cfg_we) begin
        file_open_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_cmd;
      idx_r <= in_page_index;
    end
    ptr_r        <= ptr_nxt;
    chk_addr_r   <= chk_addr_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_page_r   <= res_page_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_page_number = out_page_r;

endmodule

@@ hdl/pfla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
